/* hw/rtl/lgen_pkg.sv */
package lgen_pkg;

  localparam int GridSize = 32;
  localparam int GridN    = (GridSize > 32) ? 32 : GridSize;
  localparam int AddrW    = $clog2(GridN);
  localparam int IdxW     = 5;
  localparam int CellsW   = 32;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpStep  = 2'd1,
    OpRead  = 2'd2
  } opcode_t;

  localparam int LiveMin = 2;
  localparam int LiveMax = 3;

endpackage

/* hw/rtl/lgen_lane.sv */
module lgen_lane import lgen_pkg::*; (
  input  logic [2:0] above,
  input  logic [2:0] centre,
  input  logic [2:0] below,
  output logic       alive
);

  logic [3:0] count;

  assign count = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
               + 4'(centre[0]) + 4'(centre[2])
               + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);

  // born on three, survives on two or three
  assign alive = (count == 4'(LiveMax)) || ((count == 4'(LiveMin)) && centre[1]);

endmodule

/* hw/rtl/lgen_row.sv */
module lgen_row import lgen_pkg::*; (
  input  logic [GridN-1:0] above,
  input  logic [GridN-1:0] centre,
  input  logic [GridN-1:0] below,
  output logic [GridN-1:0] next_row
);

  // dead columns either side of the border
  logic [GridN+1:0] above_pad;
  logic [GridN+1:0] centre_pad;
  logic [GridN+1:0] below_pad;

  assign above_pad  = {1'b0, above, 1'b0};
  assign centre_pad = {1'b0, centre, 1'b0};
  assign below_pad  = {1'b0, below, 1'b0};

  for (genvar c = 0; c < GridN; c++) begin : g_lane
    lgen_lane u_lane (
      .above  (above_pad[c+2:c]),
      .centre (centre_pad[c+2:c]),
      .below  (below_pad[c+2:c]),
      .alive  (next_row[c])
    );
  end

endmodule

/* hw/rtl/life_automaton_generation.sv */
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  opcode, row_index, row_cells
// result    out        out_valid/out_stall  out_row, out_cells, last_row
//
// A write gives no result; a read result appears the cycle after the read is taken.
// A step updates all 32 rows, one row of 32 column lanes per cycle while the output is not stalled,
// paced by the single grid read port and by the one-entry output register.
// Requests are stalled while a step runs and while an unclaimed result blocks the output.
// rst is synchronous and clears the whole grid to dead cells.
module life_automaton_generation import lgen_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [IdxW-1:0]   row_index,
  input  logic [CellsW-1:0] row_cells,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IdxW-1:0]   out_row,
  output logic [CellsW-1:0] out_cells,
  output logic              last_row
);

  typedef enum logic {
    Idle,
    Step
  } state_t;

  state_t           state;
  logic [GridN-1:0] grid [GridN];
  logic [AddrW-1:0] cnt;
  logic [GridN-1:0] prev;
  logic [GridN-1:0] cur;

  logic             out_free;
  logic             accept;
  logic             load;
  logic             idx_ok;
  logic [AddrW-1:0] rd_addr;
  logic [GridN-1:0] rd_row;
  logic             last;
  logic [GridN-1:0] below;
  logic [GridN-1:0] new_row;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != Idle) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign idx_ok   = 32'(row_index) < GridN;
  assign last     = (cnt == AddrW'(GridN - 1));
  assign load     = ((state == Idle) && accept && (opcode == OpRead))
                 || ((state == Step) && out_free);

  always_comb begin
    if (state == Step) begin
      rd_addr = AddrW'(cnt + 1'b1);
    end else begin
      rd_addr = row_index[AddrW-1:0];
    end
  end

  assign rd_row = grid[rd_addr];
  assign below  = last ? '0 : rd_row;

  lgen_row u_row (
    .above    (prev),
    .centre   (cur),
    .below    (below),
    .next_row (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= Idle;
      out_valid <= 1'b0;
      cnt       <= '0;
      for (int r = 0; r < GridN; r++) begin
        grid[r] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        Idle: begin
          if (accept) begin
            unique case (opcode)
              OpWrite: begin
                if (idx_ok) begin
                  grid[row_index[AddrW-1:0]] <= row_cells[GridN-1:0];
                end
              end
              OpStep: begin
                prev  <= '0;
                cur   <= grid[0];
                cnt   <= '0;
                state <= Step;
              end
              OpRead: begin
                out_row   <= row_index;
                out_cells <= idx_ok ? CellsW'(rd_row) : '0;
                last_row  <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        Step: begin
          if (out_free) begin
            grid[cnt] <= new_row;
            out_row   <= IdxW'(cnt);
            out_cells <= CellsW'(new_row);
            last_row  <= last;
            prev      <= cur;
            cur       <= below;
            cnt       <= AddrW'(cnt + 1'b1);
            if (last) begin
              state <= Idle;
            end
          end
        end
        default: state <= Idle;
      endcase
    end
  end

endmodule

/* hw/rtl/lgen_checker.sv */
module lgen_checker import lgen_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        opcode,
  input logic [IdxW-1:0]   row_index,
  input logic [CellsW-1:0] row_cells,
  input logic              out_valid,
  input logic              out_stall,
  input logic [IdxW-1:0]   out_row,
  input logic [CellsW-1:0] out_cells,
  input logic              last_row
);

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_cells)
      && $stable(last_row))
    else $error("stalled result changed");

  // a taken read answers next cycle with its own row
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OpRead
      |=> out_valid && out_row == $past(row_index) && last_row)
    else $error("read result wrong");

  // mid-step rows keep requests out
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> in_stall)
    else $error("request taken during step");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OpWrite && !out_valid |=> !out_valid)
    else $error("write produced a result");

endmodule

bind life_automaton_generation lgen_checker u_chk (.*);
